// ----- hw/rtl/boxavg_pkg.sv -----
// ----------------------------------------------------------------------------
// boxavg_pkg: shared types and constants of the box average downscaler
// Register indexes, channel modes, queue entry flags, divider states.
// ----------------------------------------------------------------------------
package boxavg_pkg;

  // Channel count and byte width of a pixel
  localparam int NUM_CH  = 4;
  localparam int BYTE_W  = 8;

  // Configuration register widths
  localparam int SCALE_W    = 5;
  localparam int SIZE_W     = 13;
  localparam int MODE_W     = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Height clamp sits at the register maximum, so rows need one extra bit
  localparam int ROW_CMP_W = SIZE_W + 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Divider: quotient bits per channel, one bit per cycle
  localparam int QUO_W  = BYTE_W;
  localparam int STEP_W = $clog2(QUO_W);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE        = 2'd0,
    CFG_SRC_WIDTH    = 2'd1,
    CFG_SRC_HEIGHT   = 2'd2,
    CFG_CHANNEL_MODE = 2'd3
  } cfg_idx_e;

  // Channel mode codes (the fourth code acts as four channels)
  localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGBA = 2'd2;

  // Divider sequencer states
  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_HOLD = 2'd2
  } div_state_e;

  // Position flags that travel with a finished block
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } blk_flags_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic afull;
    logic full;
  } q_stat_t;

endpackage

// ----- hw/rtl/boxavg_in_if.sv -----
// ----------------------------------------------------------------------------
// boxavg_in_if: source pixel channel
// Valid/ready handshake carrying the four bytes of one source pixel.
// ----------------------------------------------------------------------------
interface boxavg_in_if;
  logic                            valid;
  logic                            ready;
  logic [boxavg_pkg::BYTE_W-1:0]   ch0;
  logic [boxavg_pkg::BYTE_W-1:0]   ch1;
  logic [boxavg_pkg::BYTE_W-1:0]   ch2;
  logic [boxavg_pkg::BYTE_W-1:0]   ch3;

  modport source (output valid, output ch0, output ch1, output ch2, output ch3,
                  input ready);
  modport sink   (input valid, input ch0, input ch1, input ch2, input ch3,
                  output ready);
endinterface

// ----- hw/rtl/boxavg_out_if.sv -----
// ----------------------------------------------------------------------------
// boxavg_out_if: output pixel channel
// Valid/ready handshake carrying one averaged pixel and its position flags.
// ----------------------------------------------------------------------------
interface boxavg_out_if;
  logic                            valid;
  logic                            ready;
  logic [boxavg_pkg::BYTE_W-1:0]   out_ch0;
  logic [boxavg_pkg::BYTE_W-1:0]   out_ch1;
  logic [boxavg_pkg::BYTE_W-1:0]   out_ch2;
  logic [boxavg_pkg::BYTE_W-1:0]   out_ch3;
  logic                            row_end;
  logic                            frame_end;

  modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                  output out_ch3, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_ch0, input out_ch1, input out_ch2,
                  input out_ch3, input row_end, input frame_end,
                  output ready);
endinterface

// ----- hw/rtl/boxavg_fifo.sv -----
// ----------------------------------------------------------------------------
// boxavg_fifo: block queue between front and back
// Small register FIFO with first-word fall-through read and status flags.
// ----------------------------------------------------------------------------
module boxavg_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_W-1:0]    wdata_i,
  input  logic                 pop_i,
  output logic [DATA_W-1:0]    rdata_o,
  output boxavg_pkg::q_stat_t  stat_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.afull = (cnt_q >= CNT_W'(DEPTH - 1));
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));

endmodule

// ----- hw/rtl/boxavg_front.sv -----
// ----------------------------------------------------------------------------
// boxavg_front: pixel intake, block classification and column line store
// Tracks raster position, accumulates channel sums per output column with a
// registered read-modify-write, and queues every completed block.
// ----------------------------------------------------------------------------
module boxavg_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(MAX_SCALE+1)-1:0]       s_i,
  input  logic [$clog2(MAX_WIDTH):0]           w_i,
  input  logic [boxavg_pkg::SIZE_W-1:0]        h_i,
  input  logic [boxavg_pkg::MODE_W-1:0]        mode_i,
  input  logic                                 q_afull_i,
  boxavg_in_if.sink                            pix,
  output logic                                 q_push_o,
  output logic [boxavg_pkg::NUM_CH-1:0][8+2*$clog2(MAX_SCALE+1)-1:0] q_sums_o,
  output boxavg_pkg::blk_flags_t               q_flags_o
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int W_W   = AW + 1;
  localparam int S_W   = $clog2(MAX_SCALE + 1);
  localparam int PH_W  = $clog2(MAX_SCALE);
  localparam int SUM_W = 8 + 2 * S_W;
  localparam int P_W   = W_W + S_W + 1;
  localparam int R_W   = boxavg_pkg::ROW_CMP_W;
  localparam int NCH   = boxavg_pkg::NUM_CH;

  typedef logic [NCH-1:0][SUM_W-1:0]              sums_t;
  typedef logic [NCH-1:0][boxavg_pkg::BYTE_W-1:0] bytes_t;

  // raster counters
  logic [AW-1:0]                 src_col_q, src_col_d;
  logic [boxavg_pkg::SIZE_W-1:0] src_row_q, src_row_d;
  logic [PH_W-1:0]               col_phase_q, col_phase_d;
  logic [PH_W-1:0]               row_phase_q, row_phase_d;
  logic [AW-1:0]                 out_col_q, out_col_d;

  // classification
  logic            acc, upd;
  logic [PH_W-1:0] sm1, cp, rp;
  logic [P_W-1:0]  blk_right;
  logic            in_col, in_row, rend, fend, fresh, emit;
  logic            use_rgb, use_alpha;
  bytes_t          pix_v;

  // accumulate stage
  logic                   b_vld_q;
  logic [AW-1:0]          b_addr_q;
  logic                   b_fresh_q;
  logic                   b_emit_q;
  boxavg_pkg::blk_flags_t b_flags_q;
  bytes_t                 b_pix_q;
  sums_t                  rd_data_q;

  // last write, for forwarding into a back-to-back hit on the same column
  logic                   wr_vld_q;
  logic [AW-1:0]          wr_addr_q;
  sums_t                  wr_data_q;
  logic                   fwd;
  sums_t                  sum_new;

  sums_t                  line_mem [MAX_WIDTH];

  assign pix.ready = !q_afull_i;
  assign acc       = pix.valid && pix.ready;

  // masked channels
  assign use_rgb   = (mode_i != boxavg_pkg::MODE_GRAY);
  assign use_alpha = (mode_i != boxavg_pkg::MODE_GRAY) && (mode_i != boxavg_pkg::MODE_RGB);
  assign pix_v[0]  = pix.ch0;
  assign pix_v[1]  = use_rgb   ? pix.ch1 : '0;
  assign pix_v[2]  = use_rgb   ? pix.ch2 : '0;
  assign pix_v[3]  = use_alpha ? pix.ch3 : '0;

  // block position and membership of the current pixel
  always_comb begin
    sm1       = PH_W'(s_i - S_W'(1));
    cp        = (col_phase_q < sm1) ? col_phase_q : sm1;
    rp        = (row_phase_q < sm1) ? row_phase_q : sm1;
    // right edge of this output column's block: (out_col + 1) * S
    blk_right = (P_W'(out_col_q) + P_W'(1)) * P_W'(s_i);
    in_col    = (blk_right <= P_W'(w_i));
    rend      = in_col && ((blk_right + P_W'(s_i)) > P_W'(w_i));
    in_row    = (R_W'(src_row_q) + R_W'(s_i)) <= (R_W'(h_i) + R_W'(rp));
    fend      = rend && ((R_W'(src_row_q) + R_W'(1) + R_W'(s_i)) > R_W'(h_i));
    fresh     = (cp == '0) && (rp == '0);
    emit      = (cp == sm1) && (rp == sm1);
    upd       = acc && in_col && in_row;
  end

  // raster counter advance
  always_comb begin
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    col_phase_d = col_phase_q;
    row_phase_d = row_phase_q;
    out_col_d   = out_col_q;
    if (acc) begin
      if (cp >= sm1) begin
        col_phase_d = '0;
        out_col_d   = out_col_q + AW'(1);
      end else begin
        col_phase_d = col_phase_q + PH_W'(1);
      end
      if ((W_W'(src_col_q) + W_W'(1)) >= w_i) begin
        src_col_d   = '0;
        col_phase_d = '0;
        out_col_d   = '0;
        if ((R_W'(src_row_q) + R_W'(1)) >= R_W'(h_i)) begin
          src_row_d   = '0;
          row_phase_d = '0;
        end else begin
          src_row_d   = src_row_q + boxavg_pkg::SIZE_W'(1);
          row_phase_d = (rp >= sm1) ? '0 : row_phase_q + PH_W'(1);
        end
      end else begin
        src_col_d = src_col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      col_phase_q <= '0;
      row_phase_q <= '0;
      out_col_q   <= '0;
      b_vld_q     <= 1'b0;
      wr_vld_q    <= 1'b0;
    end else begin
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      col_phase_q <= col_phase_d;
      row_phase_q <= row_phase_d;
      out_col_q   <= out_col_d;
      b_vld_q     <= upd;
      wr_vld_q    <= b_vld_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (upd) begin
      b_addr_q            <= out_col_q;
      b_fresh_q           <= fresh;
      b_emit_q            <= emit;
      b_flags_q.row_end   <= rend;
      b_flags_q.frame_end <= fend;
      b_pix_q             <= pix_v;
    end
    if (b_vld_q) begin
      wr_addr_q <= b_addr_q;
      wr_data_q <= sum_new;
    end
  end

  // line store: registered read in intake, write from accumulate stage
  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      line_mem[b_addr_q] <= sum_new;
    end
    if (upd) begin
      rd_data_q <= line_mem[out_col_q];
    end
  end

  // accumulate
  assign fwd = wr_vld_q && (wr_addr_q == b_addr_q);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (b_fresh_q) begin
        sum_new[c] = SUM_W'(b_pix_q[c]);
      end else if (fwd) begin
        sum_new[c] = wr_data_q[c] + SUM_W'(b_pix_q[c]);
      end else begin
        sum_new[c] = rd_data_q[c] + SUM_W'(b_pix_q[c]);
      end
    end
  end

  assign q_push_o  = b_vld_q && b_emit_q;
  assign q_sums_o  = sum_new;
  assign q_flags_o = b_flags_q;

endmodule

// ----- hw/rtl/boxavg_back.sv -----
// ----------------------------------------------------------------------------
// boxavg_back: block average divider and output register
// Restoring divider, one quotient bit per cycle for all channels at once,
// followed by an output register toward the pixel sink.
// ----------------------------------------------------------------------------
module boxavg_back #(
  parameter int MAX_SCALE = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(MAX_SCALE+1)-1:0]       s_i,
  input  logic                                 q_empty_i,
  input  logic [boxavg_pkg::NUM_CH-1:0][8+2*$clog2(MAX_SCALE+1)-1:0] q_sums_i,
  input  boxavg_pkg::blk_flags_t               q_flags_i,
  output logic                                 q_pop_o,
  boxavg_out_if.source                         avg
);

  localparam int S_W   = $clog2(MAX_SCALE + 1);
  localparam int A_W   = 2 * S_W;
  localparam int SUM_W = 8 + A_W;
  localparam int NCH   = boxavg_pkg::NUM_CH;
  localparam int QW    = boxavg_pkg::QUO_W;
  localparam int STW   = boxavg_pkg::STEP_W;

  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;
  typedef logic [NCH-1:0][QW-1:0]    quo_t;

  boxavg_pkg::div_state_e state_q, state_d;
  sums_t                  rem_q, rem_d, rem_step;
  logic [SUM_W-1:0]       dvs_q, dvs_d;
  quo_t                   quo_q, quo_d, quo_step;
  logic [STW-1:0]         step_q, step_d;
  boxavg_pkg::blk_flags_t flags_q, flags_d;

  logic [A_W-1:0]         area;
  logic                   slot_free, load_out;
  logic                   out_vld_q;
  quo_t                   out_q;
  boxavg_pkg::blk_flags_t out_flags_q;

  assign area      = A_W'(s_i) * A_W'(s_i);
  assign slot_free = !out_vld_q || avg.ready;

  // one restoring step per channel against the shared shifted divisor
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (rem_q[c] >= dvs_q) begin
        rem_step[c] = rem_q[c] - dvs_q;
        quo_step[c] = {quo_q[c][QW-2:0], 1'b1};
      end else begin
        rem_step[c] = rem_q[c];
        quo_step[c] = {quo_q[c][QW-2:0], 1'b0};
      end
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    quo_d    = quo_q;
    step_d   = step_q;
    flags_d  = flags_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      boxavg_pkg::DIV_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          rem_d   = q_sums_i;
          dvs_d   = SUM_W'(area) << (QW - 1);
          quo_d   = '0;
          step_d  = '0;
          flags_d = q_flags_i;
          state_d = boxavg_pkg::DIV_RUN;
        end
      end
      boxavg_pkg::DIV_RUN: begin
        rem_d  = rem_step;
        quo_d  = quo_step;
        dvs_d  = dvs_q >> 1;
        step_d = step_q + STW'(1);
        if (step_q == STW'(QW - 1)) begin
          if (slot_free) begin
            load_out = 1'b1;
            state_d  = boxavg_pkg::DIV_IDLE;
          end else begin
            state_d  = boxavg_pkg::DIV_HOLD;
          end
        end
      end
      boxavg_pkg::DIV_HOLD: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = boxavg_pkg::DIV_IDLE;
        end
      end
      default: begin
        state_d = boxavg_pkg::DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= boxavg_pkg::DIV_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (avg.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
    flags_q <= flags_d;
    if (load_out) begin
      out_q       <= (state_q == boxavg_pkg::DIV_RUN) ? quo_step : quo_q;
      out_flags_q <= flags_q;
    end
  end

  assign avg.valid     = out_vld_q;
  assign avg.out_ch0   = out_q[0];
  assign avg.out_ch1   = out_q[1];
  assign avg.out_ch2   = out_q[2];
  assign avg.out_ch3   = out_q[3];
  assign avg.row_end   = out_flags_q.row_end;
  assign avg.frame_end = out_flags_q.frame_end;

endmodule

// ----- hw/rtl/box_average_downscale_core.sv -----
// ----------------------------------------------------------------------------
// box_average_downscale_core: box-filter image downscaler, top level
// Pixels: one per cycle while the 4-entry block queue holds fewer than three
// blocks; each block's result is produced by the 8-step divider.
// Results: divider load plus 8 quotient steps per block, one block at a time.
// Reset: async active low; counters and queue clear, line store not cleared.
// ----------------------------------------------------------------------------
module box_average_downscale_core #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [boxavg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [boxavg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  boxavg_in_if.sink                            pix_in,
  boxavg_out_if.source                         avg_out
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int W_W   = AW + 1;
  localparam int S_W   = $clog2(MAX_SCALE + 1);
  localparam int SUM_W = 8 + 2 * S_W;
  localparam int NCH   = boxavg_pkg::NUM_CH;
  localparam int Q_W   = NCH * SUM_W + $bits(boxavg_pkg::blk_flags_t);

  // configuration registers
  logic [boxavg_pkg::SCALE_W-1:0] scale_q;
  logic [boxavg_pkg::SIZE_W-1:0]  src_width_q;
  logic [boxavg_pkg::SIZE_W-1:0]  src_height_q;
  logic [boxavg_pkg::MODE_W-1:0]  channel_mode_q;

  // effective values after saturation
  logic [S_W-1:0]                 s_eff;
  logic [W_W-1:0]                 w_eff;
  logic [boxavg_pkg::SIZE_W-1:0]  h_eff;

  // queue wiring
  logic                           q_push, q_pop;
  logic [NCH-1:0][SUM_W-1:0]      push_sums, pop_sums;
  boxavg_pkg::blk_flags_t         push_flags, pop_flags;
  boxavg_pkg::q_stat_t            q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q        <= boxavg_pkg::SCALE_W'(1);
      src_width_q    <= boxavg_pkg::SIZE_W'(1);
      src_height_q   <= boxavg_pkg::SIZE_W'(1);
      channel_mode_q <= boxavg_pkg::MODE_RGB;
    end else if (cfg_we_i) begin
      unique case (boxavg_pkg::cfg_idx_e'(cfg_idx_i))
        boxavg_pkg::CFG_SCALE:        scale_q        <= cfg_wdata_i[boxavg_pkg::SCALE_W-1:0];
        boxavg_pkg::CFG_SRC_WIDTH:    src_width_q    <= cfg_wdata_i[boxavg_pkg::SIZE_W-1:0];
        boxavg_pkg::CFG_SRC_HEIGHT:   src_height_q   <= cfg_wdata_i[boxavg_pkg::SIZE_W-1:0];
        boxavg_pkg::CFG_CHANNEL_MODE: channel_mode_q <= cfg_wdata_i[boxavg_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize saturates
  always_comb begin
    if (scale_q == '0) begin
      s_eff = S_W'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      s_eff = S_W'(MAX_SCALE);
    end else begin
      s_eff = S_W'(scale_q);
    end
    if (src_width_q == '0) begin
      w_eff = W_W'(1);
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(src_width_q);
    end
    h_eff = (src_height_q == '0) ? boxavg_pkg::SIZE_W'(1) : src_height_q;
  end

  boxavg_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_i       (s_eff),
    .w_i       (w_eff),
    .h_i       (h_eff),
    .mode_i    (channel_mode_q),
    .q_afull_i (q_stat.afull),
    .pix       (pix_in),
    .q_push_o  (q_push),
    .q_sums_o  (push_sums),
    .q_flags_o (push_flags)
  );

  boxavg_fifo #(
    .DATA_W (Q_W),
    .DEPTH  (boxavg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({push_sums, push_flags}),
    .pop_i   (q_pop),
    .rdata_o ({pop_sums, pop_flags}),
    .stat_o  (q_stat)
  );

  boxavg_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_i       (s_eff),
    .q_empty_i (q_stat.empty),
    .q_sums_i  (pop_sums),
    .q_flags_i (pop_flags),
    .q_pop_o   (q_pop),
    .avg       (avg_out)
  );

`ifndef SYNTHESIS
  // intake throttling must keep the queue from overflowing
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("block queue push while full");

  // divider only loads a queued block
  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("block queue pop while empty");

  // last pixel of a frame is always the last of its row
  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (avg_out.valid && avg_out.frame_end) |-> avg_out.row_end)
    else $error("frame end without row end");
`endif

endmodule
